>>> rtl/kmp_pkg.sv
// Package for the streaming KMP matcher: command codes, output widths,
// and the result record. No dependencies.
package kmp_pkg;

  localparam int MAX_PATTERN_DEF   = 128;
  localparam int POSITION_BITS_DEF = 32;
  localparam int OUT_W             = 32;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_TEXT   = 2'd2;

  typedef struct packed {
    logic             found;
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] stop;
    logic             error;
  } result_t;

endpackage

>>> rtl/kmp_stream_matcher.sv
// Streaming Knuth-Morris-Pratt matcher: pattern and failure-link memories,
// sequencer and result register. Depends on kmp_pkg.
//
// The block keeps a pattern of up to MAX_PATTERN bytes with its failure-link
// table and scans a byte stream for every occurrence, overlapping ones
// included. Each input transaction carries cmd and data_byte: clear empties
// the pattern and rewinds the text position, append adds one pattern byte and
// extends the failure links, text feeds one text byte. Every input transaction
// yields exactly one output transaction; a text byte that completes a match
// reports match_found with the 1-based start and end positions (positions
// wrap modulo 2^POSITION_BITS and are cut or zero-extended to 32 bits).
// Appending to a full pattern or sending text with an empty pattern returns
// error and changes nothing; cmd value 3 returns an all-zero result.
// Timing: clear, errors, cmd 3 and the first append finish in the accept
// cycle. Other appends and text bytes go from the accept to ST_LOOK, a
// synchronous read of the pattern and link memories, and on to ST_CMP, the
// compare; each failure link walked repeats the ST_LOOK and ST_CMP pair. A
// completed match adds ST_TAIL and ST_FIN to fetch the link of the last
// pattern byte. One item is in flight at a time; the input is ready again as
// soon as the result sits in the output register, and a result not yet taken
// holds the block only if a second result is ready before it drains.
module kmp_stream_matcher
  import kmp_pkg::*;
#(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       cmd,
  input  logic [7:0]       data_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             match_found,
  output logic [OUT_W-1:0] match_start,
  output logic [OUT_W-1:0] match_end,
  output logic             error
);

  localparam int IDX_W = $clog2(MAX_PATTERN);
  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int POS_W = POSITION_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOOK = 3'd1;  // memory read in flight
  localparam logic [2:0] ST_CMP  = 3'd2;  // compare byte, maybe walk a link
  localparam logic [2:0] ST_TAIL = 3'd3;  // read link of last pattern byte
  localparam logic [2:0] ST_FIN  = 3'd4;  // report match
  localparam logic [2:0] ST_OUT  = 3'd5;  // result waits for output slot

  // Storage
  logic [7:0]       pattern_store [MAX_PATTERN];
  logic [IDX_W-1:0] failure_links [MAX_PATTERN];
  logic [7:0]       ps_q;
  logic [IDX_W-1:0] fl_q;

  // Control state
  logic [2:0]       state;
  logic [CNT_W-1:0] pattern_count;
  logic [IDX_W-1:0] prefix_length;
  logic [IDX_W-1:0] matched_count;
  logic [POS_W-1:0] text_position;
  logic [CNT_W-1:0] k;
  logic [7:0]       b_reg;
  logic             is_text;
  result_t          pend;

  // Datapath
  logic             in_fire;
  logic             full;
  logic [IDX_W-1:0] k_idx;
  logic [IDX_W-1:0] cnt_idx;
  logic             ps_hit;
  logic             k_walk;
  logic [CNT_W-1:0] k_new;
  logic [POS_W-1:0] start_pos;
  logic             slot_free;
  logic             fin_valid;
  result_t          fin;
  logic             ps_we;
  logic             fl_we;
  logic [IDX_W-1:0] fl_wdata;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign full      = (pattern_count == CNT_W'(MAX_PATTERN));
  assign k_idx     = k[IDX_W-1:0];
  assign cnt_idx   = pattern_count[IDX_W-1:0];
  assign ps_hit    = (ps_q == b_reg);
  assign k_walk    = (k != '0) && !ps_hit;
  assign k_new     = k + CNT_W'(ps_hit);
  assign start_pos = text_position - POS_W'(pattern_count) + POS_W'(1);
  assign slot_free = !out_valid || out_ready;

  // Memory writes: byte on append accept, link on first append or search end
  assign ps_we    = in_fire && (cmd == CMD_APPEND) && !full;
  assign fl_we    = (ps_we && (pattern_count == '0)) ||
                    ((state == ST_CMP) && !k_walk && !is_text);
  assign fl_wdata = (state == ST_IDLE) ? '0 : k_new[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (ps_we) begin
      pattern_store[cnt_idx] <= data_byte;
    end
    if (fl_we) begin
      failure_links[cnt_idx] <= fl_wdata;
    end
    ps_q <= pattern_store[k_idx];
    fl_q <= failure_links[k_idx - IDX_W'(1)];
  end

  // Result of the current step, if it finishes now
  always_comb begin
    fin_valid = 1'b0;
    fin       = '0;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          fin_valid = !(cmd inside {CMD_APPEND, CMD_TEXT}) ||
                      ((cmd == CMD_APPEND) && (full || (pattern_count == '0))) ||
                      ((cmd == CMD_TEXT) && (pattern_count == '0));
          fin.error = ((cmd == CMD_APPEND) && full) ||
                      ((cmd == CMD_TEXT) && (pattern_count == '0));
        end
      end
      ST_CMP: begin
        fin_valid = !k_walk && !(is_text && (k_new == pattern_count));
      end
      ST_FIN: begin
        fin_valid = 1'b1;
        fin.found = 1'b1;
        fin.start = OUT_W'(start_pos);
        fin.stop  = OUT_W'(text_position);
      end
      default: begin
        fin_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      pattern_count <= '0;
      prefix_length <= '0;
      matched_count <= '0;
      text_position <= '0;
    end else begin
      // drained, and nothing new loads the output register this cycle
      if (out_valid && out_ready && !fin_valid && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            case (cmd)
              CMD_CLEAR: begin
                pattern_count <= '0;
                prefix_length <= '0;
                matched_count <= '0;
                text_position <= '0;
              end
              CMD_APPEND: begin
                if (!full) begin
                  if (pattern_count == '0) begin
                    prefix_length <= '0;
                    pattern_count <= CNT_W'(1);
                  end else begin
                    k       <= CNT_W'(prefix_length);
                    b_reg   <= data_byte;
                    is_text <= 1'b0;
                    state   <= ST_LOOK;
                  end
                end
              end
              CMD_TEXT: begin
                if (pattern_count != '0) begin
                  text_position <= text_position + POS_W'(1);
                  k       <= (CNT_W'(matched_count) >= pattern_count) ? '0 :
                             CNT_W'(matched_count);
                  b_reg   <= data_byte;
                  is_text <= 1'b1;
                  state   <= ST_LOOK;
                end
              end
              default: begin
                // unused code: the finish path returns the all-zero result
              end
            endcase
          end
        end
        ST_LOOK: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (k_walk) begin
            k     <= CNT_W'(fl_q);
            state <= ST_LOOK;
          end else if (!is_text) begin
            prefix_length <= k_new[IDX_W-1:0];
            pattern_count <= pattern_count + CNT_W'(1);
          end else if (k_new == pattern_count) begin
            k     <= k_new;  // link read at k-1 = last pattern byte
            state <= ST_TAIL;
          end else begin
            matched_count <= k_new[IDX_W-1:0];
          end
        end
        ST_TAIL: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          matched_count <= fl_q;
        end
        ST_OUT: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            match_found <= pend.found;
            match_start <= pend.start;
            match_end   <= pend.stop;
            error       <= pend.error;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Finished step: straight into the output register, or park it
      if (fin_valid) begin
        if (slot_free) begin
          out_valid   <= 1'b1;
          match_found <= fin.found;
          match_start <= fin.start;
          match_end   <= fin.stop;
          error       <= fin.error;
          state       <= ST_IDLE;
        end else begin
          pend  <= fin;
          state <= ST_OUT;
        end
      end
    end
  end

  // Checks
  a_matched_bound: assert property (@(posedge clk) disable iff (rst)
    (CNT_W'(matched_count) < pattern_count) || (pattern_count == '0))
    else $error("matched count reached pattern length");

  a_prefix_bound: assert property (@(posedge clk) disable iff (rst)
    (CNT_W'(prefix_length) < pattern_count) || (pattern_count == '0))
    else $error("border length reached pattern length");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_fire && (cmd == CMD_CLEAR) |=> (pattern_count == '0) && (text_position == '0))
    else $error("clear left state behind");

  a_err_no_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> !match_found && (match_start == '0) && (match_end == '0))
    else $error("error result carries match data");

endmodule

>>> tb/kmp_stream_matcher_test.sv
// Self-checking testbench for kmp_stream_matcher: a clocked driver and monitor,
// a behavioral KMP predictor and a queue of expected results.
// Depends on kmp_pkg and the kmp_stream_matcher RTL.
module kmp_stream_matcher_test
  import kmp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         MAX_PAT    = MAX_PATTERN_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;  // no operation, block answers all-zero
  localparam int         PRINT_CAP  = 25;    // mismatch lines shown before going quiet

  typedef struct {
    logic [1:0] op;
    logic [7:0] value;
  } stim_item_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [1:0]       cmd       = CMD_CLEAR;
  logic [7:0]       data_byte = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             match_found;
  logic [OUT_W-1:0] match_start;
  logic [OUT_W-1:0] match_end;
  logic             error;

  always #2 clk = ~clk;

  kmp_stream_matcher DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .match_found(match_found),
    .match_start(match_start),
    .match_end  (match_end),
    .error      (error)
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  stim_item_t  pending_items[$];     // filled by the sequence, drained by the driver
  result_t     expected_results[$];  // one entry per accepted input transaction

  // Handshake knobs: written by the sequence at the falling edge, read at the rising.
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_left = 0;     // long receiver hold-off, counted down below

  int unsigned counted_items  = 0;   // stimulus items excluding the unused opcode
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned matches_seen   = 0;
  int unsigned errors_seen    = 0;

  // ---------------------------------------------------------------------------
  // KMP predictor: its own copy of the pattern, border table and scan state.
  // Only entries below stored_len are ever read, so stale contents left over
  // from before a clear never matter.
  // ---------------------------------------------------------------------------
  logic [7:0]  pattern_bytes [MAX_PAT];
  logic [6:0]  border_links  [MAX_PAT];
  int unsigned stored_len  = 0;
  int unsigned border_len  = 0;
  int unsigned matched_len = 0;
  logic [31:0] text_count  = '0;

  function automatic void predict_result(input logic [1:0] op, input logic [7:0] b);
    result_t     r;
    int unsigned k;
    r = '0;
    case (op)
      CMD_CLEAR: begin
        stored_len  = 0;
        border_len  = 0;
        matched_len = 0;
        text_count  = '0;
      end
      CMD_APPEND: begin
        if (stored_len >= MAX_PAT) begin
          r.error = 1'b1;                       // pattern full, nothing changes
        end else begin
          pattern_bytes[stored_len] = b;
          if (stored_len == 0) begin
            border_len      = 0;
            border_links[0] = '0;
          end else begin
            // extend the border of the pattern by one byte
            k = border_len;
            while (k > 0 && pattern_bytes[k] != b) k = 32'(border_links[k-1]);
            if (pattern_bytes[k] == b) k++;
            border_len               = k;
            border_links[stored_len] = 7'(k);
          end
          stored_len++;
        end
      end
      CMD_TEXT: begin
        if (stored_len == 0) begin
          r.error = 1'b1;                       // no pattern, position holds
        end else begin
          text_count = text_count + 32'd1;
          k = matched_len;
          if (k >= stored_len) k = 0;
          while (k > 0 && pattern_bytes[k] != b) k = 32'(border_links[k-1]);
          if (pattern_bytes[k] == b) k++;
          if (k == stored_len) begin
            r.found     = 1'b1;
            r.start     = text_count - 32'(stored_len) + 32'd1;
            r.stop      = text_count;
            matched_len = 32'(border_links[k-1]);  // keep overlapping matches alive
          end else begin
            matched_len = k;
          end
        end
      end
      default: ;                                // unused opcode: all-zero result
    endcase
    expected_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers the next pending item once the previous one is taken.
  // The expectation is produced at the edge that accepts the transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    stim_item_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_result(cmd, data_byte);
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          item      = pending_items.pop_front();
          in_valid  <= 1'b1;
          cmd       <= item.op;
          data_byte <= item.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off timer for the receiver.
  always @(posedge clk) begin
    if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each output transaction with the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (match_found === 1'b1) matches_seen++;
        if (error === 1'b1) errors_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no transaction pending", match_end, '0);
        end else begin
          want = expected_results.pop_front();
          if (match_found !== want.found)
            report_mismatch("match_found", 32'(match_found), 32'(want.found));
          if (match_start !== want.start) report_mismatch("match_start", match_start, want.start);
          if (match_end !== want.stop)    report_mismatch("match_end", match_end, want.stop);
          if (error !== want.error)
            report_mismatch("error", 32'(error), 32'(want.error));
        end
      end
      out_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void push_item(input logic [1:0] op, input logic [7:0] value);
    stim_item_t item;
    item.op    = op;
    item.value = value;
    pending_items.push_back(item);
    if (op != CMD_UNUSED) counted_items++;
  endfunction

  // Sender holds back until every transaction is through the block.
  task automatic wait_for_drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Directed corners: empty-pattern text, unused opcode, overlapping matches,
  // append while scanning, and the extreme byte values.
  task automatic directed_items();
    push_item(CMD_CLEAR,  8'h00);
    push_item(CMD_TEXT,   8'h41);   // text with no pattern -> error
    push_item(CMD_UNUSED, 8'hFF);   // ignored
    push_item(CMD_APPEND, 8'h61);
    push_item(CMD_APPEND, 8'h61);
    push_item(CMD_TEXT,   8'h61);
    push_item(CMD_TEXT,   8'h61);   // match 1..2
    push_item(CMD_TEXT,   8'h61);   // overlapping match 2..3
    push_item(CMD_TEXT,   8'h61);   // and 3..4
    push_item(CMD_APPEND, 8'h62);   // grow the pattern mid-scan: "aab"
    push_item(CMD_TEXT,   8'h61);
    push_item(CMD_TEXT,   8'h62);   // partial match carried across the append
    push_item(CMD_CLEAR,  8'hFF);
    push_item(CMD_APPEND, 8'h00);
    push_item(CMD_APPEND, 8'hFF);
    push_item(CMD_TEXT,   8'h00);
    push_item(CMD_TEXT,   8'hFF);
    push_item(CMD_TEXT,   8'h00);
    push_item(CMD_TEXT,   8'hFF);
    push_item(CMD_TEXT,   8'h7F);   // matches no pattern byte
    push_item(CMD_UNUSED, 8'h00);
    push_item(CMD_TEXT,   8'hFF);
  endtask

  // Fills the pattern to capacity with a periodic string, overflows it, then
  // scans text matching in full, a byte forcing a deep walk, six more bytes.
  task automatic full_pattern_round();
    logic [7:0]  unit_bytes [5];
    logic [7:0]  letter_a, letter_b;
    int unsigned period, i;
    letter_a = 8'($urandom);
    letter_b = ~letter_a;
    period   = $urandom_range(5, 1);
    for (i = 0; i < 5; i++) unit_bytes[i] = $urandom_range(1) ? letter_a : letter_b;
    push_item(CMD_CLEAR, 8'($urandom));
    for (i = 0; i < MAX_PAT; i++) push_item(CMD_APPEND, unit_bytes[i % period]);
    push_item(CMD_APPEND, 8'($urandom));      // full -> error
    push_item(CMD_APPEND, 8'($urandom));
    for (i = 0; i < MAX_PAT + period + 2; i++) push_item(CMD_TEXT, unit_bytes[i % period]);
    push_item(CMD_TEXT, letter_a ^ 8'h55);    // mismatch after a long prefix
    for (i = 0; i < 6; i++) push_item(CMD_TEXT, unit_bytes[i % period]);
  endtask

  // One random round: mostly a short pattern over a small alphabet and text
  // that often embeds it; the rest is noise or text sent to an empty pattern.
  task automatic random_round();
    logic [7:0]  letters [4];
    logic [7:0]  pat [$];
    int unsigned n_letters, pat_size, text_len, embed_at, kind, i, j;
    for (i = 0; i < 4; i++) letters[i] = 8'($urandom);
    kind = $urandom_range(99);
    if (kind < 72) begin
      n_letters = $urandom_range(4, 2);
      if ($urandom_range(4) != 0) push_item(CMD_CLEAR, 8'($urandom));
      pat_size = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
      for (i = 0; i < pat_size; i++) pat.push_back(letters[$urandom_range(n_letters - 1)]);
      foreach (pat[p]) push_item(CMD_APPEND, pat[p]);
      text_len = $urandom_range(30, 5);
      embed_at = $urandom_range(1) ? $urandom_range(text_len - 1) : text_len;
      for (i = 0; i < text_len; i++) begin
        if (i == embed_at)
          for (j = 0; j < pat.size(); j++) push_item(CMD_TEXT, pat[j]);
        if ($urandom_range(29) == 0)
          push_item(CMD_APPEND, letters[$urandom_range(n_letters - 1)]);
        else if ($urandom_range(9) == 0)
          push_item(CMD_TEXT, 8'($urandom));
        else
          push_item(CMD_TEXT, letters[$urandom_range(n_letters - 1)]);
      end
    end else if (kind < 88) begin
      for (i = $urandom_range(15, 5); i > 0; i--)
        push_item(2'($urandom_range(3)), 8'($urandom));
    end else begin
      push_item(CMD_CLEAR, 8'($urandom));
      for (i = $urandom_range(3, 1); i > 0; i--) push_item(CMD_TEXT, 8'($urandom));
    end
  endtask

  // Main sequence: reset, directed corners, a full pattern, then four
  // handshake phases of random rounds, draining between phases.
  initial begin : sequencer
    int unsigned phase;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    directed_items();
    full_pattern_round();
    wait_for_drain();
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 67; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 67; end
        default: begin tx_idle_pct = 6;  rx_stall_pct = 6;  end
      endcase
      // receiver holds off while the sender keeps offering: the block backs up
      if (phase == 0) rx_hold_left = 400;
      while (counted_items < 300 + (phase + 1) * 140) random_round();
      wait_for_drain();
    end
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (300) @(negedge clk);
    $display("Checked %0d output transactions: %0d matches, %0d error results.",
             results_seen, matches_seen, errors_seen);
    $display("Covered directed corners, a full 128-byte pattern and four handshake phases.");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(5_000_000);
    $display("Timeout with %0d transactions outstanding", expected_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> kmp_stream_matcher.f
rtl/kmp_pkg.sv
rtl/kmp_stream_matcher.sv
tb/kmp_stream_matcher_test.sv
